@@ rtl/core/puyw_pkg.sv @@
package puyw_pkg;

    localparam int SOURCE_WIDTH  = 160;
    localparam int SOURCE_HEIGHT = 144;
    localparam int MAX_SCALE     = 4;

    localparam int PAIRS_PER_ROW = (SOURCE_WIDTH + 1) / 2;

    localparam int PIXEL_W    = 24;
    localparam int WORD_W     = 32;
    localparam int ADDR_W     = 18;
    localparam int SCALE_W    = 3;
    localparam int OFFSET_W   = 10;
    localparam int STRIDE_W   = OFFSET_W - 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;

    localparam int COL_W = (PAIRS_PER_ROW > 1) ? $clog2(PAIRS_PER_ROW) : 1;
    localparam int ROW_W = (SOURCE_HEIGHT > 1) ? $clog2(SOURCE_HEIGHT) : 1;
    localparam int GX_W  = COL_W + 1;
    localparam int CNT_W = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;

    localparam int POS_W = $clog2((1 << OFFSET_W) + 2 * PAIRS_PER_ROW * MAX_SCALE
                                  + 2 * MAX_SCALE);
    localparam int SY_W  = $clog2((1 << OFFSET_W) + SOURCE_HEIGHT * MAX_SCALE
                                  + MAX_SCALE);
    localparam int PROD_W = SY_W + STRIDE_W;
    localparam int SUM_W  = PROD_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd4;

    localparam logic [SCALE_W-1:0]  RESET_SCALE        = 3'd3;
    localparam logic [OFFSET_W-1:0] RESET_X_OFFSET     = 10'd80;
    localparam logic [OFFSET_W-1:0] RESET_Y_OFFSET     = 10'd24;
    localparam logic [OFFSET_W-1:0] RESET_FRAME_WIDTH  = 10'd640;
    localparam logic [OFFSET_W-1:0] RESET_FRAME_HEIGHT = 10'd480;

    // Reciprocal of 1000 scaled by 2^28, rounded up; exact for dividends below 2^18.
    localparam logic [18:0] RECIP_1000 = 19'd268436;

    typedef struct packed {
        logic [PIXEL_W-1:0] pixel_a;
        logic [PIXEL_W-1:0] pixel_b;
        logic               frame_start;
    } puyw_in_t;

    typedef struct packed {
        logic [ADDR_W-1:0] word_address;
        logic [WORD_W-1:0] word_data;
        logic              last;
    } puyw_out_t;

    typedef struct packed {
        logic [SCALE_W-1:0]  k;
        logic [CNT_W-1:0]    k_m1;
        logic [POS_W-1:0]    base;
        logic [SY_W-1:0]     ybase;
        logic [STRIDE_W-1:0] stride;
        logic [OFFSET_W-1:0] frame_height;
    } puyw_job_t;

    function automatic logic [7:0] div1000(input logic [17:0] v);
        logic [36:0] p;
        p = {19'b0, v} * {18'b0, RECIP_1000};
        return p[35:28];
    endfunction

    function automatic logic [7:0] chroma_byte(input logic neg, input logic [7:0] q);
        logic signed [9:0] v;
        v = neg ? -$signed({2'b0, q}) : $signed({2'b0, q});
        v = v + 10'sd128;
        if (v < 10'sd0) begin
            return 8'd0;
        end else if (v > 10'sd255) begin
            return 8'd255;
        end
        return v[7:0];
    endfunction

endpackage

@@ rtl/core/puyw_yuv_lane.sv @@
module puyw_yuv_lane import puyw_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    input  logic [PIXEL_W-1:0] rgb,
    output logic               out_valid,
    output logic [WORD_W-1:0]  word
);

    logic [7:0] r, g, b;
    logic signed [18:0] rs, gs, bs;

    logic [2:0] valid_reg, valid_next;
    logic [17:0] y_sum_reg, y_sum_next;
    logic signed [18:0] cb_sum_reg, cb_sum_next;
    logic signed [18:0] cr_sum_reg, cr_sum_next;

    logic [17:0] cb_mag, cr_mag;
    logic [7:0] y_q_reg, y_q_next;
    logic [7:0] cb_q_reg, cb_q_next;
    logic [7:0] cr_q_reg, cr_q_next;
    logic cb_neg_reg, cb_neg_next;
    logic cr_neg_reg, cr_neg_next;

    logic [WORD_W-1:0] word_reg, word_next;
    logic [7:0] cb_byte, cr_byte;

    assign r  = rgb[23:16];
    assign g  = rgb[15:8];
    assign b  = rgb[7:0];
    assign rs = $signed({11'b0, r});
    assign gs = $signed({11'b0, g});
    assign bs = $signed({11'b0, b});

    assign y_sum_next  = {10'b0, r} * 18'd299 + {10'b0, g} * 18'd587 + {10'b0, b} * 18'd114;
    assign cb_sum_next = bs * 19'sd500 - rs * 19'sd169 - gs * 19'sd331;
    assign cr_sum_next = rs * 19'sd500 - gs * 19'sd419 - bs * 19'sd81;

    assign cb_mag = cb_sum_reg[18] ? 18'(-cb_sum_reg) : cb_sum_reg[17:0];
    assign cr_mag = cr_sum_reg[18] ? 18'(-cr_sum_reg) : cr_sum_reg[17:0];

    assign y_q_next    = div1000(y_sum_reg);
    assign cb_q_next   = div1000(cb_mag);
    assign cr_q_next   = div1000(cr_mag);
    assign cb_neg_next = cb_sum_reg[18];
    assign cr_neg_next = cr_sum_reg[18];

    assign cb_byte   = chroma_byte(cb_neg_reg, cb_q_reg);
    assign cr_byte   = chroma_byte(cr_neg_reg, cr_q_reg);
    assign word_next = {y_q_reg, cb_byte, y_q_reg, cr_byte};

    assign valid_next = {valid_reg[1:0], in_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        y_sum_reg  <= y_sum_next;
        cb_sum_reg <= cb_sum_next;
        cr_sum_reg <= cr_sum_next;
        y_q_reg    <= y_q_next;
        cb_q_reg   <= cb_q_next;
        cr_q_reg   <= cr_q_next;
        cb_neg_reg <= cb_neg_next;
        cr_neg_reg <= cr_neg_next;
        if (valid_reg[1]) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg[2];
    assign word      = word_reg;

endmodule

@@ rtl/core/puyw_write_seq.sv @@
module puyw_write_seq import puyw_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  puyw_job_t         job,
    input  logic [WORD_W-1:0] word_a,
    input  logic [WORD_W-1:0] word_b,
    output logic              m_valid,
    input  logic              m_ready,
    output puyw_out_t         m_item,
    output logic              done
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_FLUSH = 2'd2;

    logic [1:0] state_reg, state_next;
    logic [CNT_W-1:0] sy_reg, sy_next;
    logic [CNT_W-1:0] s_reg, s_next;
    logic sel_reg, sel_next;

    logic pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [WORD_W-1:0] pend_data_reg, pend_data_next;

    logic m_valid_reg, m_valid_next;
    puyw_out_t m_item_reg, m_item_next;

    logic [POS_W-1:0] w_sum;
    logic [POS_W-2:0] w;
    logic [SY_W-1:0] out_row;
    logic [PROD_W-1:0] row_start;
    logic [SUM_W-1:0] addr_sum;
    logic cand_ok, out_free, push, push_fire, flush_fire, last_step;

    assign w_sum = job.base + (sel_reg ? POS_W'(job.k) : POS_W'(0)) + POS_W'(s_reg);
    assign w     = w_sum[POS_W-1:1];
    assign out_row   = job.ybase + SY_W'(sy_reg);
    assign row_start = PROD_W'(out_row) * PROD_W'(job.stride);
    assign addr_sum  = SUM_W'(row_start) + SUM_W'(w);
    assign cand_ok   = (out_row < SY_W'(job.frame_height))
                    && ((POS_W-1)'(w) < (POS_W-1)'(job.stride));

    assign out_free  = !m_valid_reg || m_ready;
    assign last_step = sel_reg && (s_reg == job.k_m1) && (sy_reg == job.k_m1);
    assign push      = (state_reg == ST_RUN) && cand_ok && pend_valid_reg;
    assign push_fire = push && out_free;
    assign flush_fire = (state_reg == ST_FLUSH) && pend_valid_reg && out_free;

    always_comb begin
        state_next      = state_reg;
        sy_next         = sy_reg;
        s_next          = s_reg;
        sel_next        = sel_reg;
        pend_valid_next = pend_valid_reg;
        pend_addr_next  = pend_addr_reg;
        pend_data_next  = pend_data_reg;
        done            = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    state_next      = ST_RUN;
                    sy_next         = '0;
                    s_next          = '0;
                    sel_next        = 1'b0;
                    pend_valid_next = 1'b0;
                end
            end
            ST_RUN: begin
                if (!push || out_free) begin
                    if (cand_ok) begin
                        pend_valid_next = 1'b1;
                        pend_addr_next  = addr_sum[ADDR_W-1:0];
                        pend_data_next  = sel_reg ? word_b : word_a;
                    end
                    sel_next = !sel_reg;
                    if (sel_reg) begin
                        if (s_reg == job.k_m1) begin
                            s_next  = '0;
                            sy_next = sy_reg + CNT_W'(1);
                        end else begin
                            s_next = s_reg + CNT_W'(1);
                        end
                    end
                    if (last_step) begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!pend_valid_reg || out_free) begin
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                    done            = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        m_item_next  = m_item_reg;
        if (push_fire || flush_fire) begin
            m_valid_next             = 1'b1;
            m_item_next.word_address = pend_addr_reg;
            m_item_next.word_data    = pend_data_reg;
            m_item_next.last         = flush_fire;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pend_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            pend_valid_reg <= pend_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        sy_reg        <= sy_next;
        s_reg         <= s_next;
        sel_reg       <= sel_next;
        pend_addr_reg <= pend_addr_next;
        pend_data_reg <= pend_data_next;
        m_item_reg    <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

@@ rtl/core/pixel_upscale_yuy2_writer.sv @@
// Converts pairs of RGB source pixels to YUY2 and writes each one as a block of
// scale by scale framebuffer words.
// The input channel (s_valid, s_ready, s_item) takes one pair of pixels per item,
// in raster order; frame_start restarts the column and row counters at this pair.
// The result channel (m_valid, m_ready, m_item) gives one write per item: word
// address, YUY2 data and a flag on the last write caused by the input item.
// Writes that fall outside the framebuffer are dropped, and an item whose writes
// all fall outside gives no results.
// The user writes the registers through cfg_wr_en, cfg_index and cfg_data only
// while the block is idle; the block does not enforce it. They take effect from
// the next input item. Both pixels are converted in two lanes side by side,
// each registering the sums, the quotients and the output word, after which the
// write sequencer walks the scale rows and positions, one candidate write per
// cycle unless held by a receiver stall. Each write passes through the
// sequencer's pending register and then the output register. s_ready is low from
// acceptance until the last write has been handed to the output register. When
// the receiver stalls, the sequencer holds at its next in-range write until the
// output register frees. Reset clears the counters and the handshake state and
// loads the default register values.
module pixel_upscale_yuy2_writer import puyw_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  puyw_in_t              s_item,
    output logic                  m_valid,
    input  logic                  m_ready,
    output puyw_out_t             m_item,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    logic [SCALE_W-1:0]  scale_reg, scale_next;
    logic [OFFSET_W-1:0] x_offset_reg, x_offset_next;
    logic [OFFSET_W-1:0] y_offset_reg, y_offset_next;
    logic [OFFSET_W-1:0] frame_width_reg, frame_width_next;
    logic [OFFSET_W-1:0] frame_height_reg, frame_height_next;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic busy_reg, busy_next;
    puyw_job_t job_reg, job_next;

    logic accept;
    logic [COL_W-1:0] col_eff;
    logic [ROW_W-1:0] row_eff;
    logic [GX_W-1:0] gx;
    logic [SCALE_W-1:0] k;
    logic [PIXEL_W-1:0] pixel_b_eff;

    logic lane_a_valid, lane_b_valid;
    logic [WORD_W-1:0] word_a, word_b;
    logic seq_done;

    assign accept = s_valid && s_ready;
    assign s_ready = !busy_reg;

    assign col_eff = s_item.frame_start ? '0 : col_reg;
    assign row_eff = s_item.frame_start ? '0 : row_reg;
    assign gx      = {col_eff, 1'b0};

    assign pixel_b_eff = (32'(gx) + 32'd1 >= 32'(SOURCE_WIDTH)) ? s_item.pixel_a
                                                                 : s_item.pixel_b;

    always_comb begin
        if (scale_reg == '0) begin
            k = SCALE_W'(1);
        end else if (scale_reg > SCALE_W'(MAX_SCALE)) begin
            k = SCALE_W'(MAX_SCALE);
        end else begin
            k = scale_reg;
        end
    end

    always_comb begin
        job_next.k            = k;
        job_next.k_m1         = CNT_W'(k - SCALE_W'(1));
        job_next.base         = POS_W'(x_offset_reg) + POS_W'(gx) * POS_W'(k);
        job_next.ybase        = SY_W'(y_offset_reg) + SY_W'(row_eff) * SY_W'(k);
        job_next.stride       = frame_width_reg[OFFSET_W-1:1];
        job_next.frame_height = frame_height_reg;
    end

    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        if (accept) begin
            if (col_eff == COL_W'(PAIRS_PER_ROW - 1)) begin
                col_next = '0;
                if (row_eff == ROW_W'(SOURCE_HEIGHT - 1)) begin
                    row_next = '0;
                end else begin
                    row_next = row_eff + ROW_W'(1);
                end
            end else begin
                col_next = col_eff + COL_W'(1);
                row_next = row_eff;
            end
        end
    end

    always_comb begin
        busy_next = busy_reg;
        if (accept) begin
            busy_next = 1'b1;
        end else if (seq_done) begin
            busy_next = 1'b0;
        end
    end

    always_comb begin
        scale_next        = scale_reg;
        x_offset_next     = x_offset_reg;
        y_offset_next     = y_offset_reg;
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_SCALE:        scale_next        = cfg_data[SCALE_W-1:0];
                REG_X_OFFSET:     x_offset_next     = cfg_data[OFFSET_W-1:0];
                REG_Y_OFFSET:     y_offset_next     = cfg_data[OFFSET_W-1:0];
                REG_FRAME_WIDTH:  frame_width_next  = cfg_data[OFFSET_W-1:0];
                REG_FRAME_HEIGHT: frame_height_next = cfg_data[OFFSET_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg        <= RESET_SCALE;
            x_offset_reg     <= RESET_X_OFFSET;
            y_offset_reg     <= RESET_Y_OFFSET;
            frame_width_reg  <= RESET_FRAME_WIDTH;
            frame_height_reg <= RESET_FRAME_HEIGHT;
            col_reg          <= '0;
            row_reg          <= '0;
            busy_reg         <= 1'b0;
        end else begin
            scale_reg        <= scale_next;
            x_offset_reg     <= x_offset_next;
            y_offset_reg     <= y_offset_next;
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
            col_reg          <= col_next;
            row_reg          <= row_next;
            busy_reg         <= busy_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            job_reg <= job_next;
        end
    end

    puyw_yuv_lane u_lane_a (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .rgb       (s_item.pixel_a),
        .out_valid (lane_a_valid),
        .word      (word_a)
    );

    puyw_yuv_lane u_lane_b (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (accept),
        .rgb       (pixel_b_eff),
        .out_valid (lane_b_valid),
        .word      (word_b)
    );

    puyw_write_seq u_write_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (lane_a_valid && lane_b_valid),
        .job     (job_reg),
        .word_a  (word_a),
        .word_b  (word_b),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item),
        .done    (seq_done)
    );

endmodule
